// ===== design/uirt_pkg.sv =====
package uirt_pkg;

  localparam int MAX_UNIQUE = 256;
  localparam int ID_BITS    = 32;
  localparam int ADDR_W     = $clog2(MAX_UNIQUE);
  localparam int CNT_W      = $clog2(MAX_UNIQUE + 1);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_MAP    = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

endpackage

// ===== design/unique_id_renumber_table_top.sv =====
// Sorted table of distinct ids held in one 256 x 32 memory with a registered
// read. One request is worked on at a time. Insert and map run a binary
// search, each step a memory read (S_SRCH) and a compare (S_SRCHW), then a
// check of the lower bound entry (S_CHKW); a new id then shifts every larger
// entry up one place, read (S_SHR) then write (S_SHW), before it is written
// (S_INS). A read by rank goes through S_RDW; a clear goes straight to S_DONE.
// No clearing pass is needed after reset; the table starts empty.
module unique_id_renumber_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_global_id,
  input  logic [7:0]  in_rank_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic [8:0]  out_unique_count,
  output logic [1:0]  out_status
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH  = 4'd1;
  localparam logic [3:0] S_SRCHW = 4'd2;
  localparam logic [3:0] S_CHKW  = 4'd3;
  localparam logic [3:0] S_SHR   = 4'd4;
  localparam logic [3:0] S_SHW   = 4'd5;
  localparam logic [3:0] S_INS   = 4'd6;
  localparam logic [3:0] S_RDW   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]                     state_r, state_nxt;
  logic [1:0]                     cmd_r, cmd_nxt;
  logic [uirt_pkg::ID_BITS-1:0]   id_r, id_nxt;
  logic [uirt_pkg::CNT_W-1:0]     lo_r, lo_nxt, hi_r, hi_nxt, k_r, k_nxt;
  logic [uirt_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [31:0]                    res_value_r, res_value_nxt;
  logic [1:0]                     res_status_r, res_status_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [31:0]                    out_value_r, out_value_nxt;
  logic [8:0]                     out_count_r, out_count_nxt;
  logic [1:0]                     out_status_r, out_status_nxt;

  logic                           ram_we;
  logic [uirt_pkg::ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [uirt_pkg::ID_BITS-1:0]   ram_wdata, ram_rdata;
  logic [uirt_pkg::CNT_W:0]       mid_sum;
  logic [uirt_pkg::CNT_W-1:0]     mid, k_dec;
  logic                           full;

  uirt_ram #(
    .WIDTH(uirt_pkg::ID_BITS),
    .DEPTH(uirt_pkg::MAX_UNIQUE)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[uirt_pkg::CNT_W:1];
  assign k_dec   = k_r - 1'b1;
  assign full    = (count_r == uirt_pkg::CNT_W'(uirt_pkg::MAX_UNIQUE));

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_unique_count = out_count_r;
  assign out_status       = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    k_nxt          = k_r;
    count_nxt      = count_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = k_r[uirt_pkg::ADDR_W-1:0];
    ram_wdata      = ram_rdata;
    ram_raddr      = lo_r[uirt_pkg::ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        // take a request and start on it
        if (in_valid) begin
          cmd_nxt        = in_cmd;
          id_nxt         = in_global_id;
          lo_nxt         = '0;
          hi_nxt         = count_r;
          k_nxt          = count_r;
          res_value_nxt  = '0;
          res_status_nxt = uirt_pkg::ST_OK;
          unique case (in_cmd)
            uirt_pkg::CMD_INSERT, uirt_pkg::CMD_MAP: state_nxt = S_SRCH;
            uirt_pkg::CMD_READ: begin
              ram_raddr = in_rank_index;
              if ({1'b0, in_rank_index} < count_r) begin
                state_nxt = S_RDW;
              end else begin
                res_status_nxt = uirt_pkg::ST_RANGE;
                state_nxt      = S_DONE;
              end
            end
            default: begin
              count_nxt = '0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SRCH: begin
        // probe the middle, check the lower bound entry, or finish past the end
        if (lo_r < hi_r) begin
          ram_raddr = mid[uirt_pkg::ADDR_W-1:0];
          state_nxt = S_SRCHW;
        end else if (lo_r < count_r) begin
          ram_raddr = lo_r[uirt_pkg::ADDR_W-1:0];
          state_nxt = S_CHKW;
        end else if (cmd_r == uirt_pkg::CMD_MAP) begin
          res_status_nxt = uirt_pkg::ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else if (full) begin
          res_status_nxt = uirt_pkg::ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = (k_r > lo_r) ? S_SHR : S_INS;
        end
      end
      S_SRCHW: begin
        // narrow the search window
        if (ram_rdata < id_r) begin
          lo_nxt = mid + 1'b1;
        end else begin
          hi_nxt = mid;
        end
        state_nxt = S_SRCH;
      end
      S_CHKW: begin
        // decide on the found or missing id
        if (ram_rdata == id_r) begin
          if (cmd_r == uirt_pkg::CMD_MAP) begin
            res_value_nxt = 32'(lo_r) + 32'd1;
          end
          state_nxt = S_DONE;
        end else if (cmd_r == uirt_pkg::CMD_MAP) begin
          res_status_nxt = uirt_pkg::ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else if (full) begin
          res_status_nxt = uirt_pkg::ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = (k_r > lo_r) ? S_SHR : S_INS;
        end
      end
      S_SHR: begin
        // fetch the entry below the hole
        ram_raddr = k_dec[uirt_pkg::ADDR_W-1:0];
        state_nxt = S_SHW;
      end
      S_SHW: begin
        // move it up one place
        ram_we    = 1'b1;
        ram_waddr = k_r[uirt_pkg::ADDR_W-1:0];
        ram_wdata = ram_rdata;
        k_nxt     = k_dec;
        state_nxt = (k_dec > lo_r) ? S_SHR : S_INS;
      end
      S_INS: begin
        // drop the new id into the hole
        ram_we    = 1'b1;
        ram_waddr = lo_r[uirt_pkg::ADDR_W-1:0];
        ram_wdata = id_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_RDW: begin
        res_value_nxt = ram_rdata;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        // hand the result over once the output slot is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_count_nxt  = count_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    id_r         <= id_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    k_r          <= k_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

// ===== design/uirt_ram.sv =====
module uirt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one entry, read one entry registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
